FILE: rtl/bbo_pkg.sv
`default_nettype none
package bbo_pkg;

  localparam int MAX_BOXES      = 16;
  localparam int MAX_DIMENSION  = 4096;
  localparam int HALF_THICKNESS = 2;

  localparam int CFG_W   = 13;
  localparam int FIELD_W = 16;
  localparam int PIX_W   = 8;
  localparam int OP_W    = 2;

  localparam int COORD_W = $clog2(MAX_DIMENSION);
  localparam int SC_W    = COORD_W + 2;
  localparam int CLIP_W  = ((FIELD_W > COORD_W) ? FIELD_W : COORD_W) + 2;
  localparam int CNT_W   = $clog2(MAX_BOXES + 1);
  localparam int IDX_W   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_PIXEL  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  localparam logic [PIX_W-1:0] PIX_MAX  = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0] PIX_ZERO = '0;

  typedef struct packed {
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
  } box_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    box_t             box;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } item_t;

  // Last valid coordinate for a size register, size limited to 1..MAX_DIMENSION.
  function automatic logic [COORD_W-1:0] eff_last(input logic [CFG_W-1:0] value);
    if (value == '0) begin
      return '0;
    end
    if (int'(value) > MAX_DIMENSION) begin
      return COORD_W'(MAX_DIMENSION - 1);
    end
    return COORD_W'(value - 1'b1);
  endfunction

  function automatic logic [COORD_W-1:0] clip_coord(input logic signed [CLIP_W-1:0] v,
                                                    input logic [COORD_W-1:0] hi);
    logic signed [CLIP_W-1:0] his;
    his = $signed({(CLIP_W - COORD_W)'(0), hi});
    if (v < 0) begin
      return '0;
    end
    if (v > his) begin
      return hi;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bbo_in_if.sv
`default_nettype none
interface bbo_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [bbo_pkg::OP_W-1:0]                operation;
  logic signed [bbo_pkg::FIELD_W-1:0]      box_left;
  logic signed [bbo_pkg::FIELD_W-1:0]      box_top;
  logic signed [bbo_pkg::FIELD_W-1:0]      box_width;
  logic signed [bbo_pkg::FIELD_W-1:0]      box_height;
  logic [bbo_pkg::PIX_W-1:0]               in_red;
  logic [bbo_pkg::PIX_W-1:0]               in_green;
  logic [bbo_pkg::PIX_W-1:0]               in_blue;

  modport source (output valid, operation, box_left, box_top, box_width, box_height,
                  in_red, in_green, in_blue, input ready);
  modport sink (input valid, operation, box_left, box_top, box_width, box_height,
                in_red, in_green, in_blue, output ready);
endinterface
`default_nettype wire

FILE: rtl/bbo_out_if.sv
`default_nettype none
interface bbo_out_if;
  logic                      valid;
  logic                      ready;
  logic [bbo_pkg::PIX_W-1:0] out_red;
  logic [bbo_pkg::PIX_W-1:0] out_green;
  logic [bbo_pkg::PIX_W-1:0] out_blue;
  logic                      frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/box_outline_overlay_unit.sv
`default_nettype none
// Red box outline overlay for an RGB raster stream. Requests enter on in_ch: clear (empty the
// box table, restart the frame), append (clip the box to the image and store it, up to 16
// boxes; further boxes are dropped) and pixel (one result on out_ch, forced to 255,0,0 when
// it lies on any stored box outline, with frame_end on the last pixel of the frame). A front
// stage clips boxes and feeds a 4-entry queue; the back stage tests all stored boxes at once
// and registers the result, so the block sustains one request per clock while out_ch is
// ready; a pixel passes through a queue entry and the result register. Unknown requests are
// taken and dropped. image_width (0x0) and image_height (0x4) are written over APB; the user
// must write them only while the block is idle (not enforced); sizes are limited to 1..4096.
module box_outline_overlay_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  bbo_in_if.sink                       in_ch,
  bbo_out_if.source                    out_ch,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [bbo_pkg::PADDR_W-1:0]   paddr,
  input  wire [bbo_pkg::PDATA_W-1:0]   pwdata,
  output logic [bbo_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [bbo_pkg::CFG_W-1:0]    width_r;
  logic [bbo_pkg::CFG_W-1:0]    height_r;
  logic [bbo_pkg::COORD_W-1:0]  w_last;
  logic [bbo_pkg::COORD_W-1:0]  h_last;
  logic                         reg_sel;
  logic                         cfg_wr;
  logic                         push_valid;
  logic                         push_ready;
  bbo_pkg::item_t               push_item;
  logic                         pop_valid;
  logic                         pop_ready;
  bbo_pkg::item_t               pop_item;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bbo_pkg::WIDTH_RESET;
      height_r <= bbo_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == bbo_pkg::REG_WIDTH) begin
        width_r <= pwdata[bbo_pkg::CFG_W-1:0];
      end else begin
        height_r <= pwdata[bbo_pkg::CFG_W-1:0];
      end
    end
  end

  assign prdata = (reg_sel == bbo_pkg::REG_HEIGHT)
                ? bbo_pkg::PDATA_W'(height_r) : bbo_pkg::PDATA_W'(width_r);

  assign w_last = bbo_pkg::eff_last(width_r);
  assign h_last = bbo_pkg::eff_last(height_r);

  bbo_front u_front (
    .in_ch      (in_ch),
    .w_last     (w_last),
    .h_last     (h_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  bbo_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  bbo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .w_last    (w_last),
    .h_last    (h_last),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

FILE: rtl/bbo_front.sv
`default_nettype none
module bbo_front (
  bbo_in_if.sink                      in_ch,
  input  wire [bbo_pkg::COORD_W-1:0]  w_last,
  input  wire [bbo_pkg::COORD_W-1:0]  h_last,
  output logic                        push_valid,
  input  wire                         push_ready,
  output bbo_pkg::item_t              push_item
);

  logic signed [bbo_pkg::CLIP_W-1:0] x2_sum;
  logic signed [bbo_pkg::CLIP_W-1:0] y2_sum;
  logic [bbo_pkg::COORD_W-1:0]       x1;
  logic [bbo_pkg::COORD_W-1:0]       y1;

  assign x1 = bbo_pkg::clip_coord(bbo_pkg::CLIP_W'(in_ch.box_left), w_last);
  assign y1 = bbo_pkg::clip_coord(bbo_pkg::CLIP_W'(in_ch.box_top), h_last);

  assign x2_sum = $signed({(bbo_pkg::CLIP_W - bbo_pkg::COORD_W)'(0), x1})
                + bbo_pkg::CLIP_W'(in_ch.box_width);
  assign y2_sum = $signed({(bbo_pkg::CLIP_W - bbo_pkg::COORD_W)'(0), y1})
                + bbo_pkg::CLIP_W'(in_ch.box_height);

  always_comb begin
    push_item.op     = in_ch.operation;
    push_item.box.x1 = x1;
    push_item.box.y1 = y1;
    push_item.box.x2 = bbo_pkg::clip_coord(x2_sum, w_last);
    push_item.box.y2 = bbo_pkg::clip_coord(y2_sum, h_last);
    push_item.red    = in_ch.in_red;
    push_item.green  = in_ch.in_green;
    push_item.blue   = in_ch.in_blue;
  end

  // Drop unknown operations here; they never reach the queue.
  assign push_valid  = in_ch.valid && (in_ch.operation != bbo_pkg::OP_NONE);
  assign in_ch.ready = push_ready;

endmodule
`default_nettype wire

FILE: rtl/bbo_queue.sv
`default_nettype none
module bbo_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  wire bbo_pkg::item_t  push_item,
  output logic                 pop_valid,
  input  wire                  pop_ready,
  output bbo_pkg::item_t       pop_item
);

  bbo_pkg::item_t                 entry_r [bbo_pkg::QUEUE_DEPTH];
  logic [bbo_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [bbo_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [bbo_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (count_r != bbo_pkg::QCNT_W'(bbo_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == bbo_pkg::QPTR_W'(bbo_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == bbo_pkg::QPTR_W'(bbo_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bbo_back.sv
`default_nettype none
module bbo_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire [bbo_pkg::COORD_W-1:0]  w_last,
  input  wire [bbo_pkg::COORD_W-1:0]  h_last,
  input  wire                         pop_valid,
  output logic                        pop_ready,
  input  wire bbo_pkg::item_t         pop_item,
  bbo_out_if.source                   out_ch
);

  bbo_pkg::box_t                  box_table_r [bbo_pkg::MAX_BOXES];
  logic [bbo_pkg::CNT_W-1:0]      box_count_r, box_count_nxt;
  logic [bbo_pkg::COORD_W-1:0]    col_r, col_nxt;
  logic [bbo_pkg::COORD_W-1:0]    row_r, row_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [bbo_pkg::PIX_W-1:0]      red_r, red_nxt;
  logic [bbo_pkg::PIX_W-1:0]      green_r, green_nxt;
  logic [bbo_pkg::PIX_W-1:0]      blue_r, blue_nxt;
  logic                           fend_r, fend_nxt;
  logic [bbo_pkg::MAX_BOXES-1:0]  hit_vec;
  logic                           do_pop;
  logic                           table_wr;
  logic signed [bbo_pkg::SC_W-1:0] rs;
  logic signed [bbo_pkg::SC_W-1:0] cs;
  logic signed [bbo_pkg::SC_W-1:0] thick;

  assign rs    = $signed({2'b00, row_r});
  assign cs    = $signed({2'b00, col_r});
  assign thick = $signed(bbo_pkg::SC_W'(bbo_pkg::HALF_THICKNESS));

  // Test every stored box against the current raster position at once.
  for (genvar i = 0; i < bbo_pkg::MAX_BOXES; i++) begin : g_box
    logic signed [bbo_pkg::SC_W-1:0] x1s, y1s, x2s, y2s;
    logic in_rows, in_cols, left_b, right_b, top_b, bottom_b;

    assign x1s = $signed({2'b00, box_table_r[i].x1});
    assign y1s = $signed({2'b00, box_table_r[i].y1});
    assign x2s = $signed({2'b00, box_table_r[i].x2});
    assign y2s = $signed({2'b00, box_table_r[i].y2});

    assign in_rows  = (rs >= y1s) && (rs < y2s);
    assign in_cols  = (cs >= x1s) && (cs < x2s);
    assign left_b   = in_rows && (cs >= x1s - thick) && (cs <= x1s + thick);
    assign right_b  = in_rows && (cs >= x2s - thick) && (cs <= x2s + thick);
    assign top_b    = in_cols && (rs >= y1s - thick) && (rs < y1s + thick);
    assign bottom_b = in_cols && (rs >= y2s - thick) && (rs < y2s + thick);

    assign hit_vec[i] = (box_count_r > bbo_pkg::CNT_W'(i))
                      && (left_b || right_b || top_b || bottom_b);
  end

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign do_pop    = pop_valid && pop_ready;
  assign table_wr  = do_pop && (pop_item.op == bbo_pkg::OP_APPEND)
                   && (box_count_r < bbo_pkg::CNT_W'(bbo_pkg::MAX_BOXES));

  always_comb begin
    box_count_nxt = box_count_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    fend_nxt      = fend_r;
    if (do_pop) begin
      case (pop_item.op)
        bbo_pkg::OP_CLEAR: begin
          box_count_nxt = '0;
          col_nxt       = '0;
          row_nxt       = '0;
        end
        bbo_pkg::OP_APPEND: begin
          if (table_wr) begin
            box_count_nxt = box_count_r + 1'b1;
          end
        end
        bbo_pkg::OP_PIXEL: begin
          out_valid_nxt = 1'b1;
          if (|hit_vec) begin
            red_nxt   = bbo_pkg::PIX_MAX;
            green_nxt = bbo_pkg::PIX_ZERO;
            blue_nxt  = bbo_pkg::PIX_ZERO;
          end else begin
            red_nxt   = pop_item.red;
            green_nxt = pop_item.green;
            blue_nxt  = pop_item.blue;
          end
          fend_nxt = 1'b0;
          if (col_r >= w_last) begin
            col_nxt = '0;
            if (row_r >= h_last) begin
              row_nxt  = '0;
              fend_nxt = 1'b1;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_count_r <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      box_count_r <= box_count_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    fend_r  <= fend_nxt;
    if (table_wr) begin
      box_table_r[box_count_r[bbo_pkg::IDX_W-1:0]] <= pop_item.box;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_red   = red_r;
  assign out_ch.out_green = green_r;
  assign out_ch.out_blue  = blue_r;
  assign out_ch.frame_end = fend_r;

endmodule
`default_nettype wire
